FILE: sv/ptca_pkg.sv
// Shared constants, types and helper functions of the page translation cache.
package ptca_pkg;

  localparam int PAGE_OFFSET_BITS = 12;
  localparam int INDEX_BITS       = 5;
  localparam int NUM_WAYS         = 4;

  localparam int ADDR_BITS = 64;
  localparam int TAG_BITS  = ADDR_BITS - PAGE_OFFSET_BITS;
  localparam int AGE_BITS  = 8;
  localparam int NUM_SETS  = 1 << INDEX_BITS;
  localparam int SET_W     = (INDEX_BITS > 0) ? INDEX_BITS : 1;
  localparam int WAY_BITS  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int OUT_WAY_BITS = 2;

  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_TOUCH  = 1'b1;

  typedef logic [TAG_BITS-1:0]  tag_t;
  typedef logic [AGE_BITS-1:0]  age_t;
  typedef logic [SET_W-1:0]     set_t;
  typedef logic [WAY_BITS-1:0]  way_t;
  typedef logic [NUM_WAYS-1:0]  way_mask_t;

  typedef struct packed {
    logic [NUM_WAYS-1:0][TAG_BITS-1:0] tag;
    logic [NUM_WAYS-1:0][AGE_BITS-1:0] age;
  } row_t;

  function automatic tag_t tag_of(input logic [ADDR_BITS-1:0] address);
    return address[ADDR_BITS-1:PAGE_OFFSET_BITS];
  endfunction

  function automatic set_t set_of(input logic [ADDR_BITS-1:0] address);
    if (INDEX_BITS == 0) begin
      return '0;
    end
    return address[PAGE_OFFSET_BITS +: SET_W];
  endfunction

  function automatic logic [OUT_WAY_BITS-1:0] way_field(input way_t w);
    logic [31:0] wide;
    wide = 32'(w);
    return wide[OUT_WAY_BITS-1:0];
  endfunction

endpackage

FILE: sv/ptca_req_if.sv
// Request channel: one page lookup or touch per beat.
interface ptca_req_if;
  import ptca_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [ADDR_BITS-1:0] address;

  modport source (output valid, output func, output address, input ready);
  modport sink   (input valid, input func, input address, output ready);
endinterface

FILE: sv/ptca_rsp_if.sv
// Result channel: hit, way and eviction flag, one per beat.
interface ptca_rsp_if;
  import ptca_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic [OUT_WAY_BITS-1:0] way;
  logic                    evicted;

  modport source (output valid, output hit, output way, output evicted, input ready);
  modport sink   (input valid, input hit, input way, input evicted, output ready);
endinterface

FILE: sv/page_translation_cache_aging.sv
// Top level: set-associative page cache with age-based replacement.
//
// Each request beat is answered by exactly one result beat. A new request can be
// accepted in every cycle while the result channel does not stall, so the sustained
// rate is one item per cycle. Row memory read data is registered: the set is read as
// the request enters the stage register, and all ways are then compared in one pass
// into the result register; a touch also writes the aged row back. A request to the
// set that the previous item is writing in the same cycle takes the written row by
// forwarding. Valid bits are flip-flops cleared by reset, so the block needs no
// clearing pass and accepts requests from the first cycle after reset.
module page_translation_cache_aging (
  input  logic      clk,
  input  logic      rst,
  ptca_req_if.sink  lookup,
  ptca_rsp_if.source result
);
  import ptca_pkg::*;

  row_t      mem [NUM_SETS];
  way_mask_t valid [NUM_SETS];

  logic stage_valid;
  logic stage_func;
  tag_t stage_tag;
  set_t stage_set;
  row_t rd_row;
  row_t byp_row;
  logic byp_sel;

  logic out_valid;
  logic out_hit;
  logic [OUT_WAY_BITS-1:0] out_way;
  logic out_evicted;

  logic      accept;
  logic      advance;
  logic      wr_en;
  row_t      cur_row;
  row_t      wr_row;
  way_mask_t cur_valid;
  way_mask_t match;
  logic      hit;
  way_t      hit_way;
  logic      has_empty;
  way_t      empty_way;
  way_t      oldest_way;
  way_t      victim;
  age_t      max_age;
  age_t      aged;
  logic [OUT_WAY_BITS-1:0] way_next;
  logic      evicted_next;

  assign advance      = stage_valid && (!out_valid || result.ready);
  assign lookup.ready = !stage_valid || advance;
  assign accept       = lookup.valid && lookup.ready;
  assign wr_en        = advance && (stage_func == FUNC_TOUCH);

  assign cur_row   = byp_sel ? byp_row : rd_row;
  assign cur_valid = valid[stage_set];

  always_comb begin
    match      = '0;
    hit_way    = '0;
    has_empty  = 1'b0;
    empty_way  = '0;
    oldest_way = '0;
    max_age    = '0;
    aged       = '0;
    wr_row     = cur_row;
    for (int w = 0; w < NUM_WAYS; w++) begin
      match[w] = cur_valid[w] && (cur_row.tag[w] == stage_tag);
    end
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = way_t'(w);
      end
      if (!cur_valid[w]) begin
        empty_way = way_t'(w);
      end
    end
    hit       = |match;
    has_empty = !(&cur_valid);
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (cur_valid[w]) begin
        if (match[w]) begin
          wr_row.age[w] = '0;
        end else begin
          aged = (cur_row.age[w] == AGE_MAX) ? AGE_MAX : cur_row.age[w] + age_t'(1);
          wr_row.age[w] = aged;
          if (aged > max_age) begin
            max_age    = aged;
            oldest_way = way_t'(w);
          end
        end
      end
    end
    victim = has_empty ? empty_way : oldest_way;
    if (!hit) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (way_t'(w) == victim) begin
          wr_row.tag[w] = stage_tag;
          wr_row.age[w] = '0;
        end
      end
    end
    if (stage_func == FUNC_LOOKUP) begin
      way_next     = hit ? way_field(hit_way) : '0;
      evicted_next = 1'b0;
    end else begin
      way_next     = hit ? way_field(hit_way) : way_field(victim);
      evicted_next = !hit && !has_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[stage_set] <= wr_row;
    end
    if (accept) begin
      rd_row  <= mem[set_of(lookup.address)];
      byp_row <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SETS; s++) begin
        valid[s] <= '0;
      end
    end else if (wr_en && !hit) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (way_t'(w) == victim) begin
          valid[stage_set][w] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      byp_sel     <= 1'b0;
    end else begin
      if (accept) begin
        stage_valid <= 1'b1;
        byp_sel     <= wr_en && (set_of(lookup.address) == stage_set);
      end else if (advance) begin
        stage_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_func <= lookup.func;
      stage_tag  <= tag_of(lookup.address);
      stage_set  <= set_of(lookup.address);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_hit     <= hit;
      out_way     <= way_next;
      out_evicted <= evicted_next;
    end
  end

  assign result.valid   = out_valid;
  assign result.hit     = out_hit;
  assign result.way     = out_way;
  assign result.evicted = out_evicted;

  a_stall_needs_full_output: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !advance |-> out_valid)
    else $error("Stage register held while the result register was empty.");

  a_evict_only_on_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_hit && out_evicted))
    else $error("A result reported both a hit and an eviction.");

  a_reset_empties_pipe: assert property (@(posedge clk)
    rst |=> !stage_valid && !out_valid)
    else $error("Pipeline not empty after reset.");

  a_fill_sets_valid: assert property (@(posedge clk) disable iff (rst)
    wr_en && !hit |=> valid[$past(stage_set)] != '0)
    else $error("A filled set shows no valid way.");

endmodule
